>>> rtl/set_assoc_cache_tag_lookup_assert.svh
// Assertion macros for the cache tag lookup block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH

// same-cycle implication
`define SACTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sactl_pkg.sv
// Shared constants, register codes and controller/datapath types for the
// cache tag lookup block. No dependencies.
package sactl_pkg;

  localparam int unsigned MAX_WAYS  = 8;
  localparam int unsigned WAY_W     = 3;
  localparam int unsigned WAYS_W    = 4;   // holds a way count, 0..MAX_WAYS
  localparam int unsigned SET_BITS  = 8;
  localparam int unsigned SETS      = 256;
  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned TAG_W     = ADDR_BITS;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned LINE_W    = 1 + TAG_W + STAMP_W;

  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned OUT_FIELD_W = WAY_W + 2 * CNT_W;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd3;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd6;
  localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd6;
  localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 4'd4;
  localparam logic             RST_POLICY      = POLICY_LRU;

  typedef struct packed {
    logic addr_load;   // item accepted, latch set and tag
    logic clear_step;  // clear one set after reset
    logic cmp_load;    // capture tag compare and row stamps
    logic vic_step;    // one oldest-stamp comparison
    logic commit;      // write line, bump counters, load result
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_victim;
    logic vic_done;
  } dp_stat_t;

endpackage

>>> rtl/sactl_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sactl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sactl_ctrl.sv
// Sequencing state machine for the cache tag lookup block.
// Depends on sactl_pkg; drives the datapath through ctrl_cmd_t.
module sactl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  input  sactl_pkg::dp_stat_t  stat_i,
  output sactl_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_VICT,
    ST_WRITE
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_o     = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.addr_load = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp_load = 1'b1;
        state_d        = stat_i.need_victim ? ST_VICT : ST_WRITE;
      end
      ST_VICT: begin
        if (stat_i.vic_done) begin
          state_d = ST_WRITE;
        end else begin
          cmd_o.vic_step = 1'b1;
        end
      end
      ST_WRITE: begin
        // wait until the result register is free
        if (!m_valid_q || m_ready_i) begin
          cmd_o.commit = 1'b1;
          m_valid_d    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

>>> rtl/sactl_dp.sv
// Datapath: configuration registers, address split, per-way tag/stamp RAMs,
// hit and victim search, counters and result register.
// Depends on sactl_pkg and sactl_ram.
module sactl_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sactl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sactl_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [sactl_pkg::ADDR_BITS-1:0]       addr_i,
  input  sactl_pkg::ctrl_cmd_t                  cmd_i,
  output sactl_pkg::dp_stat_t                   stat_o,
  output logic                                  out_hit_o,
  output logic                                  out_evict_o,
  output logic [sactl_pkg::OUT_FIELD_W-1:0]     out_fields_o
);

  localparam int unsigned NW  = sactl_pkg::MAX_WAYS;
  localparam int unsigned WW  = sactl_pkg::WAY_W;
  localparam int unsigned SB  = sactl_pkg::SET_BITS;
  localparam int unsigned TW  = sactl_pkg::TAG_W;
  localparam int unsigned STW = sactl_pkg::STAMP_W;
  localparam int unsigned CW  = sactl_pkg::CNT_W;
  localparam int unsigned LW  = sactl_pkg::LINE_W;
  localparam int unsigned NCW = sactl_pkg::WAYS_W;

  // configuration
  logic [sactl_pkg::CFG_W-1:0] offset_q, index_q, ways_q;
  logic                        policy_q;
  logic [NCW-1:0]              ib_eff, nw_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= sactl_pkg::RST_OFFSET_BITS;
      index_q  <= sactl_pkg::RST_INDEX_BITS;
      ways_q   <= sactl_pkg::RST_WAYS_IN_USE;
      policy_q <= sactl_pkg::RST_POLICY;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sactl_pkg::REG_OFFSET_BITS: offset_q <= cfg_data_i;
        sactl_pkg::REG_INDEX_BITS:  index_q  <= cfg_data_i;
        sactl_pkg::REG_WAYS_IN_USE: ways_q   <= cfg_data_i;
        sactl_pkg::REG_POLICY:      policy_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // set count capped at the store size, way count clamped to 1..MAX_WAYS
  assign ib_eff = (index_q > NCW'(SB)) ? NCW'(SB) : index_q;
  assign nw_eff = (ways_q == '0) ? NCW'(1) : ((ways_q > NCW'(NW)) ? NCW'(NW) : ways_q);

  // address split
  logic [sactl_pkg::ADDR_BITS-1:0] block;
  logic [SB:0]                     set_mask_w;
  logic [SB-1:0]                   set_d, set_q;
  logic [TW-1:0]                   tag_d, tag_q;

  assign block      = addr_i >> offset_q;
  assign set_mask_w = ((SB+1)'(1) << ib_eff) - (SB+1)'(1);
  assign set_d      = block[SB-1:0] & set_mask_w[SB-1:0];
  assign tag_d      = TW'(block >> ib_eff);

  // clearing sweep over the sets after reset
  logic [SB-1:0] clr_cnt_q;

  // access clock and counters
  logic [STW-1:0] clock_q, stamp_new;
  logic [CW-1:0]  hit_cnt_q, miss_cnt_q, hit_cnt_d, miss_cnt_d;

  // lookup results
  logic           hit_q, evict_q;
  logic [WW-1:0]  way_q;
  logic [STW-1:0] stamp_q [NW];
  logic [STW-1:0] best_q;
  logic [NCW-1:0] vic_idx_q;

  assign stamp_new  = clock_q + STW'(1);
  assign hit_cnt_d  = hit_cnt_q + CW'(hit_q);
  assign miss_cnt_d = miss_cnt_q + CW'(!hit_q);

  // way RAMs, one line word {valid, tag, stamp} per set
  logic [SB-1:0]  ram_addr;
  logic [LW-1:0]  ram_wdata;
  logic [LW-1:0]  ram_rdata [NW];
  logic [NW-1:0]  ram_we;
  logic           line_write;
  logic [NW-1:0]  rd_valid;
  logic [TW-1:0]  rd_tag   [NW];
  logic [STW-1:0] rd_stamp [NW];

  // FIFO hits leave the line untouched
  assign line_write = !(hit_q && (policy_q == sactl_pkg::POLICY_FIFO));
  assign ram_addr   = cmd_i.clear_step ? clr_cnt_q : set_q;
  assign ram_wdata  = cmd_i.clear_step ? '0 : {1'b1, tag_q, stamp_new};

  for (genvar g = 0; g < NW; g++) begin : g_way
    assign ram_we[g] = cmd_i.clear_step ||
                       (cmd_i.commit && line_write && (way_q == WW'(g)));

    sactl_ram #(
      .WIDTH (LW),
      .DEPTH (sactl_pkg::SETS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .addr_i  (ram_addr),
      .wdata_i (ram_wdata),
      .rdata_o (ram_rdata[g])
    );

    assign rd_valid[g] = ram_rdata[g][LW-1];
    assign rd_tag[g]   = ram_rdata[g][LW-2 -: TW];
    assign rd_stamp[g] = ram_rdata[g][STW-1:0];
  end

  // tag compare across the ways in use, lowest way wins
  logic [NW-1:0] hit_vec, inv_vec;
  logic [WW-1:0] hit_way, inv_way;

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int i = 0; i < NW; i++) begin
      hit_vec[i] = (NCW'(i) < nw_eff) && rd_valid[i] && (rd_tag[i] == tag_q);
      inv_vec[i] = (NCW'(i) < nw_eff) && !rd_valid[i];
    end
    for (int i = NW - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WW'(i);
      end
      if (inv_vec[i]) begin
        inv_way = WW'(i);
      end
    end
  end

  assign stat_o.need_victim = !(|hit_vec) && !(|inv_vec);
  assign stat_o.vic_done    = (vic_idx_q >= nw_eff);
  assign stat_o.clear_last  = (clr_cnt_q == '1);

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clock_q    <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + SB'(1);
      end
      if (cmd_i.commit) begin
        clock_q    <= stamp_new;
        hit_cnt_q  <= hit_cnt_d;
        miss_cnt_q <= miss_cnt_d;
      end
    end
  end

  // payload registers
  logic           out_hit_q, out_evict_q;
  logic [WW-1:0]  out_way_q;
  logic [CW-1:0]  out_hits_q, out_misses_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_load) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
    if (cmd_i.cmp_load) begin
      hit_q     <= |hit_vec;
      evict_q   <= stat_o.need_victim;
      way_q     <= (|hit_vec) ? hit_way : ((|inv_vec) ? inv_way : '0);
      best_q    <= rd_stamp[0];
      vic_idx_q <= NCW'(1);
      for (int i = 0; i < NW; i++) begin
        stamp_q[i] <= rd_stamp[i];
      end
    end
    // one way per cycle; strict compare keeps the lowest way on ties
    if (cmd_i.vic_step) begin
      if (stamp_q[vic_idx_q[WW-1:0]] < best_q) begin
        best_q <= stamp_q[vic_idx_q[WW-1:0]];
        way_q  <= vic_idx_q[WW-1:0];
      end
      vic_idx_q <= vic_idx_q + NCW'(1);
    end
    if (cmd_i.commit) begin
      out_hit_q    <= hit_q;
      out_evict_q  <= evict_q;
      out_way_q    <= way_q;
      out_hits_q   <= hit_cnt_d;
      out_misses_q <= miss_cnt_d;
    end
  end

  assign out_hit_o    = out_hit_q;
  assign out_evict_o  = out_evict_q;
  assign out_fields_o = {out_misses_q, out_hits_q, out_way_q};

endmodule

>>> rtl/set_assoc_cache_tag_lookup.sv
// Top level of the set-associative cache tag lookup (LRU / FIFO victim).
// Depends on sactl_pkg, sactl_ctrl, sactl_dp, sactl_ram and the assert header.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: address
//  m_axis    out        m_axis_tvalid/m_axis_tready  tuser: hit, replaced_valid
//                                                    tdata: way, hit/miss totals
//  cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// An item passes through accept, RAM read, compare and write on a hit or a
// fill, with a victim step before the write when a victim is chosen, since the
// oldest-stamp search walks the stored stamps one way per cycle.
// After reset a clearing pass over all 256 sets wipes the valid bits, one set
// per cycle, before the first item is taken; config writes are taken always.
// A stalled result holds the write-back step until the result register frees.
module set_assoc_cache_tag_lookup (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [sactl_pkg::ADDR_BITS-1:0]      s_axis_tdata,  // [31:0] address
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [sactl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // way_used, hit_total,
                                                              // miss_total, zero pad
  output logic [sactl_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // hit, replaced_valid
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sactl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sactl_pkg::CFG_W-1:0]          cfg_data_i
);

  sactl_pkg::ctrl_cmd_t                cmd;
  sactl_pkg::dp_stat_t                 stat;
  logic                                out_hit, out_evict;
  logic [sactl_pkg::OUT_FIELD_W-1:0]   out_fields;

  assign cfg_ready_o = 1'b1;

  sactl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sactl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .addr_i       (s_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_hit_o    (out_hit),
    .out_evict_o  (out_evict),
    .out_fields_o (out_fields)
  );

  assign m_axis_tdata = {{(sactl_pkg::OUT_TDATA_W - sactl_pkg::OUT_FIELD_W){1'b0}}, out_fields};
  assign m_axis_tuser = {out_evict, out_hit};

  `include "set_assoc_cache_tag_lookup_assert.svh"

  `SACTL_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                     "item accepted while busy")
  `SACTL_ASSERT_NOW(a_no_overwrite, cmd.commit, !m_axis_tvalid || m_axis_tready,
                    "pending result overwritten")
  `SACTL_ASSERT_NEXT(a_commit_shows, cmd.commit, m_axis_tvalid,
                     "committed result not presented")
  `SACTL_ASSERT_NOW(a_hit_no_evict, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1],
                    "hit reports eviction")

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for set_assoc_cache_tag_lookup: LRU/FIFO tag store lookups.
// Depends on sactl_pkg and the block's top level; predicts every result in-bench.
module tb;
  import sactl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evicted;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } lookup_result_t;

  // Shadow tag store: registers, lines, access clock and running totals.
  class tag_store_model;
    logic [CFG_W-1:0]   offset_bits, index_bits, ways_cfg;
    logic               policy;
    bit                 line_valid [SETS][MAX_WAYS];
    logic [TAG_W-1:0]   line_tag   [SETS][MAX_WAYS];
    logic [STAMP_W-1:0] line_stamp [SETS][MAX_WAYS];
    logic [STAMP_W-1:0] access_clock;
    logic [CNT_W-1:0]   hit_count, miss_count;
    lookup_result_t     expected_q[$];
    int                 errors, checked, evictions;

    function new();
      offset_bits  = RST_OFFSET_BITS;
      index_bits   = RST_INDEX_BITS;
      ways_cfg     = RST_WAYS_IN_USE;
      policy       = RST_POLICY;
      access_clock = '0;
      hit_count    = '0;
      miss_count   = '0;
      foreach (line_valid[i, j]) line_valid[i][j] = 1'b0;
    endfunction

    function int set_bits();
      return (index_bits > SET_BITS) ? SET_BITS : int'(index_bits);
    endfunction

    function int way_count();
      if (ways_cfg == 0) return 1;
      return (ways_cfg > MAX_WAYS) ? MAX_WAYS : int'(ways_cfg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_OFFSET_BITS: offset_bits = val;
        REG_INDEX_BITS:  index_bits  = val;
        REG_WAYS_IN_USE: ways_cfg    = val;
        REG_POLICY:      policy      = val[0];
        default: ;
      endcase
    endfunction

    function void note_address(logic [ADDR_BITS-1:0] addr);
      logic [ADDR_BITS-1:0] block, tag;
      int             ib, nw, set_no, way;
      bit             found;
      lookup_result_t r;
      ib     = set_bits();
      nw     = way_count();
      block  = addr >> offset_bits;
      set_no = int'(block & ((32'd1 << ib) - 32'd1));
      tag    = block >> ib;
      access_clock = access_clock + STAMP_W'(1);
      found  = 1'b0;
      way    = 0;
      r      = '0;
      for (int w = 0; w < nw && !found; w++)
        if (line_valid[set_no][w] && line_tag[set_no][w] == tag) begin
          found = 1'b1;
          way   = w;
        end
      if (found) begin
        r.hit     = 1'b1;
        hit_count = hit_count + CNT_W'(1);
        if (policy == POLICY_LRU) line_stamp[set_no][way] = access_clock;
      end else begin
        miss_count = miss_count + CNT_W'(1);
        for (int w = 0; w < nw && !found; w++)
          if (!line_valid[set_no][w]) begin
            found = 1'b1;
            way   = w;
          end
        if (!found) begin
          // oldest stamp wins, lowest way on a tie
          way = 0;
          for (int w = 1; w < nw; w++)
            if (line_stamp[set_no][w] < line_stamp[set_no][way]) way = w;
          r.evicted = 1'b1;
          evictions++;
        end
        line_valid[set_no][way] = 1'b1;
        line_tag[set_no][way]   = tag;
        line_stamp[set_no][way] = access_clock;
      end
      r.way    = way[WAY_W-1:0];
      r.hits   = hit_count;
      r.misses = miss_count;
      expected_q.push_back(r);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
      lookup_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                 $time, tdata, tuser);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      report("hit",            32'(e.hit),     32'(tuser[0]));
      report("replaced_valid", 32'(e.evicted), 32'(tuser[1]));
      report("way_used",       32'(e.way),     32'(tdata[WAY_W-1:0]));
      report("hit_total",      e.hits,         tdata[WAY_W +: CNT_W]);
      report("miss_total",     e.misses,       tdata[WAY_W+CNT_W +: CNT_W]);
      report("tdata pad",      32'd0,          32'(tdata[OUT_TDATA_W-1:OUT_FIELD_W]));
    endfunction
  endclass

  logic                       clk_i, rst_ni;
  logic                       s_axis_tvalid, s_axis_tready;
  logic [ADDR_BITS-1:0]       s_axis_tdata;
  logic                       m_axis_tvalid, m_axis_tready;
  logic [OUT_TDATA_W-1:0]     m_axis_tdata;
  logic [OUT_TUSER_W-1:0]     m_axis_tuser;
  logic                       cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_W-1:0]           cfg_data_i;

  tag_store_model tags = new();
  bit             quiet = 1'b0;
  int             cycles = 0;
  int             items_sent = 0;
  int             settings_run = 0;

  set_assoc_cache_tag_lookup uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, tags.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Monitors sample at the edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tags.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) tags.note_address(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tags.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Result side: random stall bursts, always ready once quiet.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if (!quiet) repeat ($urandom_range(0, 15)) @(posedge clk_i);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] ib,
                               input logic [CFG_W-1:0] nw, input logic [CFG_W-1:0] pol);
    write_reg(REG_OFFSET_BITS, ob);
    write_reg(REG_INDEX_BITS, ib);
    write_reg(REG_WAYS_IN_USE, nw);
    write_reg(REG_POLICY, pol);
    settings_run++;
  endtask

  task automatic send_address(input logic [ADDR_BITS-1:0] addr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Lower valid and wait for every outstanding lookup to come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tags.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ADDR_BITS-1:0] make_addr(logic [31:0] tag, int set_no,
                                                     logic [31:0] off);
    logic [63:0] a;
    int          ob, ib;
    ob = int'(tags.offset_bits);
    ib = tags.set_bits();
    a  = (64'(tag) << (ib + ob)) | (64'(set_no) << ob) | (64'(off) & ((64'd1 << ob) - 64'd1));
    return a[ADDR_BITS-1:0];
  endfunction

  task automatic random_run(input int count, input bit pause_midway);
    int          sets, nw, set_no;
    logic [31:0] tag_base;
    sets     = 1 << tags.set_bits();
    nw       = tags.way_count();
    tag_base = $urandom;
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) drain();
      if ($urandom_range(0, 3) == 0) begin
        send_address($urandom);
      end else begin
        if ($urandom_range(0, 2) != 0) set_no = $urandom_range(0, (sets > 4) ? 3 : sets - 1);
        else set_no = $urandom_range(0, sets - 1);
        send_address(make_addr(tag_base + $urandom_range(0, nw + 1), set_no, $urandom));
      end
    end
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_OFFSET_BITS;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: 4 ways, LRU; fill set 0, refresh way 0, then evict
    send_address(32'h0000_0000);
    send_address(32'h0000_003F);
    send_address(32'hFFFF_FFFF);
    for (int t = 1; t < 4; t++) send_address(make_addr(t, 0, t));
    send_address(make_addr(0, 0, 5));
    send_address(make_addr(4, 0, 0));
    send_address(make_addr(5, 0, 0));
    send_address(make_addr(0, 0, 0));
    send_address(make_addr(2, 0, 0));
    drain();

    // FIFO, two ways: a hit must not save the first-filled line
    apply_setting(4'd6, 4'd6, 4'd2, {3'b001, POLICY_FIFO});
    send_address(make_addr(10, 7, 0));
    send_address(make_addr(11, 7, 0));
    send_address(make_addr(10, 7, 1));
    send_address(make_addr(12, 7, 0));
    send_address(make_addr(10, 7, 0));
    drain();

    // oversize index, zero ways and too many ways
    apply_setting(4'd15, 4'd15, 4'd0, POLICY_LRU);
    send_address(32'hAAAA_5555);
    send_address(32'h5555_AAAA);
    send_address(32'hAAAA_5555);
    drain();
    apply_setting(4'd0, 4'd8, 4'd15, POLICY_FIFO);
    send_address(32'h8000_0001);
    send_address(32'h0000_00FF);
    send_address(32'h8000_0001);
    drain();

    random_run(90, 1'b0);
    apply_setting(4'd0, 4'd0, 4'd1, POLICY_FIFO);
    random_run(80, 1'b1);
    apply_setting(4'd15, 4'd15, 4'd15, POLICY_LRU);
    random_run(90, 1'b0);
    apply_setting(4'd0, 4'd8, 4'd8, POLICY_FIFO);
    random_run(90, 1'b0);
    apply_setting(4'd12, 4'd2, 4'd0, POLICY_LRU);
    random_run(80, 1'b0);
    apply_setting(4'd4, 4'd3, 4'd3, POLICY_FIFO);
    random_run(90, 1'b0);
    apply_setting(4'd2, 4'd1, 4'd8, POLICY_LRU);
    random_run(90, 1'b1);

    // closing stretch with no idling on either side
    quiet = 1'b1;
    apply_setting(4'd7, 4'd4, 4'd5, POLICY_LRU);
    random_run(90, 1'b0);

    repeat (30) @(posedge clk_i);
    $display("Sent %0d lookups over %0d register settings; %0d results checked.",
             items_sent, settings_run, tags.checked);
    $display("Totals seen: %0d hits, %0d misses, %0d evictions of valid lines.",
             tags.hit_count, tags.miss_count, tags.evictions);
    if (tags.errors == 0 && tags.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sactl_pkg.sv
rtl/sactl_ram.sv
rtl/sactl_ctrl.sv
rtl/sactl_dp.sv
rtl/set_assoc_cache_tag_lookup.sv
bench/tb.sv
